// ===== design/bmhq_pkg.sv =====
// Shared types and constants of the binary max-heap queue.
// Used by bmhq_ctrl, bmhq_dp, binary_max_heap_queue and binary_max_heap_queue_test; depends on nothing.
package bmhq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int EXT_W     = ADDR_W + 2;
  localparam int PRIO_W    = 32;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 11;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 80;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_last;
    logic load_last;
    logic rd_parent;
    logic up_move;
    logic rd_left;
    logic take_left;
    logic rd_right;
    logic take_right;
    logic dn_move;
    logic wr_entry;
    logic rd_root;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_remove;
    logic full;
    logic cnt_zero;
    logic pos_zero;
    logic up_less;
    logic kid_out;
    logic right_in;
    logic dn_stop;
  } sts_t;

endpackage

// ===== design/bmhq_dp.sv =====
// Datapath of the binary max-heap queue: heap memory, moving entry, walk position,
// fill count and result register. Depends on bmhq_pkg.
module bmhq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmhq_pkg::cmd_t                      cmd,
  output bmhq_pkg::sts_t                      sts,
  input  logic                                in_opcode,
  input  logic signed [bmhq_pkg::PRIO_W-1:0]  in_prio,
  input  logic signed [bmhq_pkg::DATA_W-1:0]  in_data,
  output logic [bmhq_pkg::OUT_DATA_W-1:0]     out_word
);

  bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];

  bmhq_pkg::entry_t                   rd_data_r;
  bmhq_pkg::entry_t                   entry_r;
  bmhq_pkg::entry_t                   child_r;
  logic [bmhq_pkg::ADDR_W-1:0]        pos_r;
  logic [bmhq_pkg::ADDR_W-1:0]        kid_r;
  logic [bmhq_pkg::CNT_W-1:0]         count_r;
  logic [bmhq_pkg::CNT_W-1:0]         count_nxt;
  logic [bmhq_pkg::STATUS_W-1:0]      status_r;
  logic [bmhq_pkg::STATUS_W-1:0]      status_nxt;
  logic [bmhq_pkg::OUT_DATA_W-1:0]    out_word_r;

  logic [bmhq_pkg::ADDR_W-1:0]        parent;
  logic [bmhq_pkg::ADDR_W:0]          kid_left;
  logic                               rd_en;
  logic [bmhq_pkg::ADDR_W-1:0]        rd_addr;
  logic                               wr_en;
  bmhq_pkg::entry_t                   wr_data;
  logic                               right_wins;
  bmhq_pkg::entry_t                   top;

  assign parent     = (pos_r - bmhq_pkg::ADDR_W'(1)) >> 1;
  assign kid_left   = {pos_r, 1'b1};
  assign right_wins = $signed(child_r.prio) < $signed(rd_data_r.prio);

  assign sts.op_remove = (in_opcode == bmhq_pkg::OP_REMOVE);
  assign sts.full      = (count_r == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.up_less   = $signed(entry_r.prio) < $signed(rd_data_r.prio);
  assign sts.kid_out   = bmhq_pkg::EXT_W'(kid_left) >= bmhq_pkg::EXT_W'(count_r);
  assign sts.right_in  = (bmhq_pkg::EXT_W'(kid_r) + bmhq_pkg::EXT_W'(1))
                         < bmhq_pkg::EXT_W'(count_r);
  assign sts.dn_stop   = !($signed(entry_r.prio) < $signed(child_r.prio));

  always_comb begin
    status_nxt = bmhq_pkg::STATUS_OK;
    count_nxt  = count_r;
    if (in_opcode == bmhq_pkg::OP_INSERT) begin
      if (sts.full) begin
        status_nxt = bmhq_pkg::STATUS_FULL;
      end else begin
        count_nxt = count_r + bmhq_pkg::CNT_W'(1);
      end
    end else begin
      if (sts.cnt_zero) begin
        status_nxt = bmhq_pkg::STATUS_EMPTY;
      end else begin
        count_nxt = count_r - bmhq_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    priority if (cmd.rd_last) begin
      rd_addr = count_r[bmhq_pkg::ADDR_W-1:0];
    end else if (cmd.rd_parent) begin
      rd_addr = parent;
    end else if (cmd.rd_left) begin
      rd_addr = kid_left[bmhq_pkg::ADDR_W-1:0];
    end else if (cmd.rd_right) begin
      rd_addr = kid_r + bmhq_pkg::ADDR_W'(1);
    end else if (cmd.rd_root) begin
      rd_addr = '0;
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = entry_r;
    priority if (cmd.wr_entry) begin
      wr_data = entry_r;
    end else if (cmd.up_move) begin
      wr_data = rd_data_r;
    end else if (cmd.dn_move) begin
      wr_data = child_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      entry_r  <= '{prio: in_prio, data: in_data};
      status_r <= status_nxt;
      pos_r    <= count_r[bmhq_pkg::ADDR_W-1:0];
    end
    if (cmd.load_last) begin
      entry_r <= rd_data_r;
      pos_r   <= '0;
    end
    if (cmd.up_move) begin
      pos_r <= parent;
    end
    if (cmd.dn_move) begin
      pos_r <= kid_r;
    end
    if (cmd.rd_left) begin
      kid_r <= kid_left[bmhq_pkg::ADDR_W-1:0];
    end
    if (cmd.take_left) begin
      child_r <= rd_data_r;
    end
    if (cmd.take_right && right_wins) begin
      child_r <= rd_data_r;
      kid_r   <= kid_r + bmhq_pkg::ADDR_W'(1);
    end
  end

  assign top = sts.cnt_zero ? '0 : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r <= bmhq_pkg::OUT_DATA_W'({status_r, sts.cnt_zero,
                                           bmhq_pkg::OUT_CNT_W'(count_r),
                                           top.data, top.prio});
    end
  end

  assign out_word = out_word_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
    else $error("fill count exceeds capacity");

  a_write_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (bmhq_pkg::EXT_W'(pos_r) < bmhq_pkg::EXT_W'(count_r)))
    else $error("heap write beyond the filled region");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && (status_nxt != bmhq_pkg::STATUS_OK)) |=> $stable(count_r))
    else $error("refused transfer changed the fill count");

endmodule

// ===== design/bmhq_ctrl.sv =====
// Controller of the binary max-heap queue: sequences sift-up and sift-down walks
// and the result handshake. Depends on bmhq_pkg.
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  bmhq_pkg::sts_t  sts,
  output bmhq_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_LAST_RD   = 11'b000_0000_0010,
    S_LAST_WAIT = 11'b000_0000_0100,
    S_UP_CHK    = 11'b000_0000_1000,
    S_UP_CMP    = 11'b000_0001_0000,
    S_DN_CHK    = 11'b000_0010_0000,
    S_DN_LW     = 11'b000_0100_0000,
    S_DN_RW     = 11'b000_1000_0000,
    S_DN_CMP    = 11'b001_0000_0000,
    S_ROOT_RD   = 11'b010_0000_0000,
    S_ROOT_WAIT = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.op_remove) begin
            state_nxt = sts.cnt_zero ? S_ROOT_RD : S_LAST_RD;
          end else begin
            state_nxt = sts.full ? S_ROOT_RD : S_UP_CHK;
          end
        end
      end
      S_LAST_RD: begin
        if (sts.cnt_zero) begin
          state_nxt = S_ROOT_RD;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_LAST_WAIT;
        end
      end
      S_LAST_WAIT: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_DN_CHK;
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.wr_entry = 1'b1;
          state_nxt    = S_ROOT_RD;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.wr_entry = 1'b1;
          state_nxt    = S_ROOT_RD;
        end else begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts.kid_out) begin
          cmd.wr_entry = 1'b1;
          state_nxt    = S_ROOT_RD;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_DN_LW;
        end
      end
      S_DN_LW: begin
        cmd.take_left = 1'b1;
        if (sts.right_in) begin
          cmd.rd_right = 1'b1;
          state_nxt    = S_DN_RW;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RW: begin
        cmd.take_right = 1'b1;
        state_nxt      = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_stop) begin
          cmd.wr_entry = 1'b1;
          state_nxt    = S_ROOT_RD;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_CHK;
        end
      end
      S_ROOT_RD: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transfer accepted while an item is in progress");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_result_follows_root_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && !$past(cmd.load_out)) |-> $past(cmd.rd_root) || $past(state_r == S_ROOT_WAIT))
    else $error("result loaded without a root read");

endmodule

// ===== design/binary_max_heap_queue.sv =====
// Binary max-heap priority queue of (priority, data) entries in a single-port-per-side RAM.
// An insert walks up and a remove walks down at most log2(CAPACITY) levels; a refused item
// walks no level and goes straight to the root read that forms its result.
// Each level costs one registered RAM read and a compare (up to two reads on the way down).
// One item is in progress at a time; the next is taken the cycle after its result is loaded.
// Reset (rst_n low, synchronous) empties the heap; RAM contents are not cleared.
module binary_max_heap_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bmhq_pkg::IN_DATA_W-1:0]     in_tdata,   // entry_priority, entry_data
  input  logic                               in_tuser,   // opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bmhq_pkg::OUT_DATA_W-1:0]    out_tdata   // top_priority, top_data,
                                                         // entry_count, is_empty, status
);

  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bmhq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_opcode (in_tuser),
    .in_prio   (in_tdata[bmhq_pkg::PRIO_W-1:0]),
    .in_data   (in_tdata[bmhq_pkg::PRIO_W +: bmhq_pkg::DATA_W]),
    .out_word  (out_tdata)
  );

endmodule

// ===== tb/sv/binary_max_heap_queue_test.sv =====
// Self-checking testbench for binary_max_heap_queue: drives insert and remove transfers
// with random gaps and stalls, and checks every result against a built-in heap predictor.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.
module binary_max_heap_queue_test;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;
  localparam int MIX_ITEMS    = 10;

  // Result fields, first field in the highest bits.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     empty;
    logic [OUT_CNT_W-1:0]     count;
    logic signed [DATA_W-1:0] top_data;
    logic signed [PRIO_W-1:0] top_prio;
  } heap_view_t;

  localparam int VIEW_W = $bits(heap_view_t);

  typedef struct packed {
    logic   op;
    entry_t ent;
  } heap_cmd_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = OP_INSERT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  heap_cmd_t  pending_cmds[$];
  heap_view_t expected_tops[$];
  entry_t     heap_model[CAPACITY];
  int         heap_fill = 0;
  int         plan_fill = 0;

  int n_queued = 0, n_accepted = 0, n_checked = 0, failures = 0, cycle_count = 0;
  int n_inserts = 0, n_removes = 0, n_full = 0, n_empty = 0, peak_fill = 0;
  int in_gap = 0, in_calm = 0, out_stall = 0, out_calm = 0;

  binary_max_heap_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic heap_view_t apply_heap_cmd(logic op, entry_t ent);
    heap_view_t v;
    entry_t     tmp;
    int         pos;
    int         up;
    int         kid;
    v = '0;
    v.status = STATUS_OK;
    if (op == OP_INSERT) begin
      n_inserts++;
      if (heap_fill >= CAPACITY) begin
        v.status = STATUS_FULL;
        n_full++;
      end else begin
        heap_model[heap_fill] = ent;
        pos = heap_fill;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_model[pos].prio < heap_model[up].prio) break;
          tmp = heap_model[pos];
          heap_model[pos] = heap_model[up];
          heap_model[up] = tmp;
          pos = up;
        end
        heap_fill++;
      end
    end else begin
      n_removes++;
      if (heap_fill == 0) begin
        v.status = STATUS_EMPTY;
        n_empty++;
      end else begin
        heap_fill--;
        heap_model[0] = heap_model[heap_fill];
        pos = 0;
        while (2 * pos + 1 < heap_fill) begin
          kid = 2 * pos + 1;
          if (kid + 1 < heap_fill && heap_model[kid].prio < heap_model[kid + 1].prio) kid++;
          if (!(heap_model[pos].prio < heap_model[kid].prio)) break;
          tmp = heap_model[pos];
          heap_model[pos] = heap_model[kid];
          heap_model[kid] = tmp;
          pos = kid;
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    if (heap_fill > 0) begin
      v.top_prio = heap_model[0].prio;
      v.top_data = heap_model[0].data;
    end
    v.count = heap_fill[OUT_CNT_W-1:0];
    v.empty = (heap_fill == 0);
    return v;
  endfunction

  task automatic queue_cmd(logic op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
    heap_cmd_t c;
    c.op = op;
    c.ent.prio = prio;
    c.ent.data = data;
    pending_cmds.push_back(c);
    n_queued++;
    if (op == OP_INSERT && plan_fill < CAPACITY) plan_fill++;
    if (op == OP_REMOVE && plan_fill > 0) plan_fill--;
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 31) - 16;
      8:             return 32'h7FFF_FFFF;
      9:             return 32'h8000_0000;
      default:       return $urandom;
    endcase
  endfunction

  // Input side: one item per transfer, a random gap after each one.
  always @(posedge clk) begin
    heap_cmd_t c;
    logic      next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= OP_INSERT;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        c.op = in_tuser;
        c.ent.prio = in_tdata[PRIO_W-1:0];
        c.ent.data = in_tdata[PRIO_W+DATA_W-1:PRIO_W];
        expected_tops.push_back(apply_heap_cmd(c.op, c.ent));
        n_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_tdata <= {c.ent.data, c.ent.prio};
          in_tuser <= c.op;
          next_valid = 1'b1;
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            in_gap = $urandom_range(0, 4);
            if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(10, 40);
          end
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Output side: check each result transfer, then stall for a random number of cycles.
  always @(posedge clk) begin
    heap_view_t seen;
    heap_view_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = heap_view_t'(out_tdata[VIEW_W-1:0]);
        n_checked++;
        if (expected_tops.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("ERROR: unexpected result prio=%0d data=%0d count=%0d empty=%0b status=%0d",
                     seen.top_prio, seen.top_data, seen.count, seen.empty, seen.status);
        end else begin
          want = expected_tops.pop_front();
          if (seen.top_prio !== want.top_prio || seen.top_data !== want.top_data ||
              seen.count !== want.count || seen.empty !== want.empty ||
              seen.status !== want.status) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("ERROR: result %0d (prio/data/count/empty/status)", n_checked);
              $display("  expected %0d/%0d/%0d/%0b/%0d", want.top_prio, want.top_data,
                       want.count, want.empty, want.status);
              $display("  actual   %0d/%0d/%0d/%0b/%0d", seen.top_prio, seen.top_data,
                       seen.count, seen.empty, seen.status);
            end
          end
        end
        if (out_calm > 0) begin
          out_calm--;
          out_stall = 0;
        end else begin
          out_stall = $urandom_range(0, 4);
          if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(10, 40);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_tops.size());
      $display("binary_max_heap_queue test failed");
      $finish;
    end
  end

  initial begin
    int k;
    // Empty refusal, extreme keys and payloads, ties with the maximum key.
    queue_cmd(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_cmd(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_cmd(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_cmd(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0002);
    for (k = 0; k < 6; k++) queue_cmd(OP_REMOVE, $urandom, $urandom);
    queue_cmd(OP_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_cmd(OP_INSERT, 32'd5, 32'd10);
    queue_cmd(OP_INSERT, 32'd5, 32'd11);
    queue_cmd(OP_INSERT, 32'd5, 32'd12);
    queue_cmd(OP_INSERT, 32'd5, 32'd13);
    for (k = 0; k < 5; k++) queue_cmd(OP_REMOVE, 32'h0, 32'h0);

    // Balanced mix on a shallow heap, then a climb to full, then churn at capacity.
    for (k = 0; k < MIX_ITEMS; k++)
      queue_cmd($urandom_range(0, 1) ? OP_REMOVE : OP_INSERT, rand_prio(), $urandom);
    while (plan_fill < CAPACITY)
      queue_cmd(($urandom_range(0, 39) == 0) ? OP_REMOVE : OP_INSERT, rand_prio(), $urandom);
    for (k = 0; k < 4; k++) queue_cmd(OP_INSERT, rand_prio(), $urandom);
    for (k = 0; k < MIX_ITEMS; k++)
      queue_cmd($urandom_range(0, 1) ? OP_REMOVE : OP_INSERT, rand_prio(), $urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_queued) @(posedge clk);
    while (expected_tops.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts (%0d refused as full) and %0d removes (%0d refused as empty).",
             n_inserts, n_full, n_removes, n_empty);
    $display("Heap peaked at %0d entries; %0d results checked, %0d failures.",
             peak_fill, n_checked, failures);
    if (failures == 0) begin
      $display("binary_max_heap_queue test passed");
    end else begin
      $display("binary_max_heap_queue test failed");
    end
    $finish;
  end

endmodule
